// ===== hdl/lpr_pkg.sv =====
package lpr_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int TTL_W    = 8;
   localparam int PORT_W   = 3;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ROUTE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TTL_DROP  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] gateway;
      logic              direct;
      logic [PORT_W-1:0] port;
   } entry_type;

endpackage

// ===== hdl/ipv4_longest_prefix_router.sv =====
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  op, addresses, ttl, route fields
// rsp_      out        rsp_valid / rsp_ready  status, interface, next hop, ttl
//
// add, ttl-drop and empty-table transactions skip the scan and go straight to S_DONE
// a lookup steps through S_SCAN, S_WAIT and S_FIN before S_DONE, scanning every stored route
// through the single read port of the route memory and the one masked compare
// reset is synchronous and empties the table; no clearing pass is needed
// req_ready is high whenever the sequencer is idle, even while a response waits
// a stalled response holds only the sequencer at its final step
module ipv4_longest_prefix_router
   import lpr_pkg::*;
#(
   parameter int MAX_ROUTES = 64,
   parameter int NUM_PORTS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_dest_addr,
   input  logic [TTL_W-1:0]    req_ttl_in,
   input  logic [ADDR_W-1:0]   req_route_prefix,
   input  logic [LEN_W-1:0]    req_prefix_length,
   input  logic                req_has_next_hop,
   input  logic [ADDR_W-1:0]   req_next_hop_addr,
   input  logic [PORT_W-1:0]   req_interface_num,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PORT_W-1:0]   rsp_out_interface,
   output logic [ADDR_W-1:0]   rsp_out_next_hop,
   output logic [TTL_W-1:0]    rsp_ttl_out
);

   localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CW = $clog2(MAX_ROUTES + 1);
   localparam int EW = $bits(entry_type);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                cmp_last_ff, cmp_last_in;
   logic [ADDR_W-1:0]   dest_ff, dest_in;
   logic [TTL_W-1:0]    ttl_ff, ttl_in;
   logic                best_found_ff, best_found_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [PORT_W-1:0]   best_port_ff, best_port_in;
   logic                best_direct_ff, best_direct_in;
   logic [ADDR_W-1:0]   best_gw_ff, best_gw_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [PORT_W-1:0]   res_port_ff, res_port_in;
   logic [ADDR_W-1:0]   res_hop_ff, res_hop_in;
   logic [TTL_W-1:0]    res_ttl_ff, res_ttl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic [ADDR_W-1:0]   rsp_hop_ff, rsp_hop_in;
   logic [TTL_W-1:0]    rsp_ttl_ff, rsp_ttl_in;

   logic                ram_we;
   entry_type           wr_entry;
   entry_type           rd_entry;
   logic [EW-1:0]       rd_bits;
   logic                hit;
   logic                req_fire;
   logic                table_full;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign table_full = (count_ff == CW'(MAX_ROUTES));
   assign rd_entry   = entry_type'(rd_bits);

   always_comb begin
      wr_entry.prefix  = req_route_prefix;
      wr_entry.length  = (req_prefix_length > MAX_LEN) ? MAX_LEN : req_prefix_length;
      wr_entry.gateway = req_has_next_hop ? req_next_hop_addr : '0;
      wr_entry.direct  = !req_has_next_hop;
      wr_entry.port    = (32'(req_interface_num) >= NUM_PORTS)
                         ? PORT_W'(NUM_PORTS - 1) : req_interface_num;
   end

   lpr_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ROUTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_bits)
   );

   lpr_match u_match (
      .addr     (dest_ff),
      .prefix   (rd_entry.prefix),
      .length   (rd_entry.length),
      .best_len (best_len_ff),
      .hit      (hit)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      cmp_vld_in     = 1'b0;
      cmp_last_in    = 1'b0;
      dest_in        = dest_ff;
      ttl_in         = ttl_ff;
      best_found_in  = best_found_ff;
      best_len_in    = best_len_ff;
      best_port_in   = best_port_ff;
      best_direct_in = best_direct_ff;
      best_gw_in     = best_gw_ff;
      res_status_in  = res_status_ff;
      res_port_in    = res_port_ff;
      res_hop_in     = res_hop_ff;
      res_ttl_in     = res_ttl_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_hop_in     = rsp_hop_ff;
      rsp_ttl_in     = rsp_ttl_ff;
      ram_we         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // compare stage, one entry per cycle
      if (cmp_vld_ff && hit) begin
         best_found_in  = 1'b1;
         best_len_in    = rd_entry.length;
         best_port_in   = rd_entry.port;
         best_direct_in = rd_entry.direct;
         best_gw_in     = rd_entry.gateway;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dest_in       = req_dest_addr;
               ttl_in        = req_ttl_in;
               best_found_in = 1'b0;
               best_len_in   = '0;
               scan_in       = '0;
               res_port_in   = '0;
               res_hop_in    = '0;
               res_ttl_in    = '0;
               state_in      = S_DONE;
               if (req_op == OP_ADD) begin
                  if (table_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_status_in = ST_ADDED;
                  end
               end else if (req_ttl_in <= TTL_W'(1)) begin
                  res_status_in = ST_TTL_DROP;
               end else if (count_ff == '0) begin
                  res_status_in = ST_NO_ROUTE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmp_vld_in  = 1'b1;
            cmp_last_in = (scan_ff == count_ff - CW'(1));
            scan_in     = scan_ff + CW'(1);
            if (cmp_last_in) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (best_found_ff) begin
               res_status_in = ST_FORWARDED;
               res_port_in   = best_port_ff;
               res_hop_in    = best_direct_ff ? dest_ff : best_gw_ff;
               res_ttl_in    = ttl_ff - TTL_W'(1);
            end else begin
               res_status_in = ST_NO_ROUTE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_port_in   = res_port_ff;
               rsp_hop_in    = res_hop_ff;
               rsp_ttl_in    = res_ttl_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         cmp_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_last_ff  <= cmp_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      dest_ff        <= dest_in;
      ttl_ff         <= ttl_in;
      best_found_ff  <= best_found_in;
      best_len_ff    <= best_len_in;
      best_port_ff   <= best_port_in;
      best_direct_ff <= best_direct_in;
      best_gw_ff     <= best_gw_in;
      res_status_ff  <= res_status_in;
      res_port_ff    <= res_port_in;
      res_hop_ff     <= res_hop_in;
      res_ttl_ff     <= res_ttl_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_hop_ff     <= rsp_hop_in;
      rsp_ttl_ff     <= rsp_ttl_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_interface = rsp_port_ff;
   assign rsp_out_next_hop  = rsp_hop_ff;
   assign rsp_ttl_out       = rsp_ttl_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ROUTES))
      else $error("route count beyond table depth");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_ADD && !table_full) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted add did not grow the table");

   a_wait_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (cmp_vld_ff && cmp_last_ff))
      else $error("scan ended before the last entry was compared");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_FORWARDED) |->
         (rsp_port_ff == '0 && rsp_hop_ff == '0 && rsp_ttl_ff == '0))
      else $error("non-forwarded transaction carries route fields");

endmodule

// ===== hdl/lpr_ram.sv =====
module lpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lpr_match.sv =====
module lpr_match
   import lpr_pkg::*;
(
   input  logic [ADDR_W-1:0] addr,
   input  logic [ADDR_W-1:0] prefix,
   input  logic [LEN_W-1:0]  length,
   input  logic [LEN_W-1:0]  best_len,
   output logic              hit
);

   logic [ADDR_W-1:0] mask;

   // length 0 gives an empty mask, 32 a full one
   assign mask = ~({ADDR_W{1'b1}} >> length);
   assign hit  = (((addr ^ prefix) & mask) == '0) && (length >= best_len);

endmodule
